// ===== rtl/lfs_pkg.sv =====
// shared types and constants for the lifo stack with lcg fill
// no dependencies; imported by every module of the block
package lfs_pkg;

    localparam int DATA_W    = 32;
    localparam int COUNT_W   = 9;
    localparam int LEVEL_W   = 9;
    localparam int SEED_BITS = 31;
    localparam int SPAN_W    = DATA_W + 1;
    localparam int DEPTH_DEF = 256;

    // generator constants
    localparam logic [DATA_W-1:0] LCG_MUL = 32'd1103515245;
    localparam logic [DATA_W-1:0] LCG_ADD = 32'd12345;

    // operation codes
    localparam logic [1:0] MODE_PUSH  = 2'd0;
    localparam logic [1:0] MODE_GROUP = 2'd1;
    localparam logic [1:0] MODE_POP   = 2'd2;
    localparam logic [1:0] MODE_CLEAR = 2'd3;

    // result status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_EMPTY    = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd2;
    localparam logic [1:0] STATUS_RANGE    = 2'd3;

    // sequencer to generator controls
    typedef struct packed {
        logic load;
        logic step;
    } gen_ctrl_t;

    // generator to sequencer status
    typedef struct packed {
        logic                 done;
        logic [SEED_BITS-1:0] rem;
    } gen_stat_t;

endpackage

// ===== rtl/lifo_stack_with_lcg_fill_unit.sv =====
// lifo stack with lcg group fill: push, pop, clear, group push; one result per command
// done is registered from S_WAIT: push, clear and range error pass S_READ, S_WAIT; pop adds S_POP, S_POPW;
// a group push loops S_CHECK and S_GEN per value, each value waiting on the 31-step remainder divider
// busy drops when the result is shown, so a new start can be taken in the done cycle itself
// results cannot be stalled; rst_n is asynchronous, clears the level, store contents undefined
// depends on lfs_pkg, lfs_gen, lfs_mem
module lifo_stack_with_lcg_fill_unit #(
    parameter int DEPTH = lfs_pkg::DEPTH_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    start,
    output logic                                    busy,
    input  logic [1:0]                              mode,
    input  logic signed [lfs_pkg::DATA_W-1:0]       push_value,
    input  logic signed [lfs_pkg::DATA_W-1:0]       range_low,
    input  logic signed [lfs_pkg::DATA_W-1:0]       range_high,
    input  logic signed [lfs_pkg::DATA_W-1:0]       start_seed,
    input  logic [lfs_pkg::COUNT_W-1:0]             fill_count,
    output logic                                    done,
    output logic signed [lfs_pkg::DATA_W-1:0]       popped_value,
    output logic signed [lfs_pkg::DATA_W-1:0]       top_value,
    output logic                                    is_empty,
    output logic [lfs_pkg::LEVEL_W-1:0]             fill_level,
    output logic [1:0]                              status
);
    import lfs_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int LW = $clog2(DEPTH + 1);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_CHECK = 7'b0000010,
        S_GEN   = 7'b0000100,
        S_POP   = 7'b0001000,
        S_POPW  = 7'b0010000,
        S_READ  = 7'b0100000,
        S_WAIT  = 7'b1000000
    } state_t;

    state_t                 state_reg,  state_next;
    logic [LW-1:0]          level_reg,  level_next;
    logic [1:0]             status_reg, status_next;
    logic [DATA_W-1:0]      popped_reg, popped_next;
    logic [DATA_W-1:0]      lo_reg,     lo_next;
    logic [SPAN_W-1:0]      span_reg,   span_next;
    logic [COUNT_W-1:0]     count_reg,  count_next;

    logic                   done_reg;
    logic [DATA_W-1:0]      popped_out_reg;
    logic [DATA_W-1:0]      top_out_reg;
    logic                   empty_out_reg;
    logic [LW-1:0]          level_out_reg;
    logic [1:0]             status_out_reg;

    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    logic [DATA_W-1:0]      mem_wdata;
    logic                   mem_re;
    logic [AW-1:0]          mem_raddr;
    logic [DATA_W-1:0]      mem_rdata;

    gen_ctrl_t              gen_ctrl;
    gen_stat_t              gen_stat;

    logic                   full;
    logic [SPAN_W-1:0]      span_in;

    assign full    = (level_reg >= LW'(DEPTH));
    assign span_in = {range_high[DATA_W-1], range_high}
                   - {range_low[DATA_W-1], range_low} + SPAN_W'(1);

    // generator and remainder unit
    lfs_gen u_gen (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (gen_ctrl),
        .load_seed (start_seed),
        .span      (span_reg),
        .stat      (gen_stat)
    );

    // entry store
    lfs_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        level_next    = level_reg;
        status_next   = status_reg;
        popped_next   = popped_reg;
        lo_next       = lo_reg;
        span_next     = span_reg;
        count_next    = count_reg;
        mem_we        = 1'b0;
        mem_waddr     = level_reg[AW-1:0];
        mem_wdata     = push_value;
        mem_re        = 1'b0;
        mem_raddr     = level_reg[AW-1:0];
        gen_ctrl.load = 1'b0;
        gen_ctrl.step = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    status_next = STATUS_OK;
                    popped_next = '0;
                    state_next  = S_READ;
                    unique case (mode)
                        MODE_PUSH:
                        begin
                            if (full)
                            begin
                                status_next = STATUS_OVERFLOW;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                level_next = level_reg + LW'(1);
                            end
                        end
                        MODE_GROUP:
                        begin
                            if (range_low > range_high)
                            begin
                                status_next = STATUS_RANGE;
                            end
                            else
                            begin
                                lo_next       = range_low;
                                span_next     = span_in;
                                count_next    = fill_count;
                                gen_ctrl.load = 1'b1;
                                state_next    = S_CHECK;
                            end
                        end
                        MODE_POP:
                        begin
                            if (level_reg == '0)
                            begin
                                status_next = STATUS_EMPTY;
                            end
                            else
                            begin
                                level_next = level_reg - LW'(1);
                                state_next = S_POP;
                            end
                        end
                        MODE_CLEAR:
                        begin
                            level_next = '0;
                        end
                        default:
                        begin
                            state_next = S_READ;
                        end
                    endcase
                end
            end
            S_CHECK:
            begin
                if (count_reg == '0)
                begin
                    state_next = S_READ;
                end
                else if (full)
                begin
                    status_next = STATUS_OVERFLOW;
                    state_next  = S_READ;
                end
                else
                begin
                    gen_ctrl.step = 1'b1;
                    state_next    = S_GEN;
                end
            end
            S_GEN:
            begin
                if (gen_stat.done)
                begin
                    mem_we     = 1'b1;
                    mem_wdata  = lo_reg + DATA_W'(gen_stat.rem);
                    level_next = level_reg + LW'(1);
                    count_next = count_reg - COUNT_W'(1);
                    state_next = S_CHECK;
                end
            end
            S_POP:
            begin
                mem_re     = 1'b1;
                state_next = S_POPW;
            end
            S_POPW:
            begin
                popped_next = mem_rdata;
                state_next  = S_READ;
            end
            S_READ:
            begin
                mem_re     = (level_reg != '0);
                mem_raddr  = level_reg[AW-1:0] - AW'(1);
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            level_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            level_reg <= level_next;
            done_reg  <= (state_reg == S_WAIT);
        end
    end

    // working and result registers
    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        popped_reg <= popped_next;
        lo_reg     <= lo_next;
        span_reg   <= span_next;
        count_reg  <= count_next;
        if (state_reg == S_WAIT)
        begin
            popped_out_reg <= popped_reg;
            top_out_reg    <= (level_reg == '0) ? {DATA_W{1'b1}} : mem_rdata;
            empty_out_reg  <= (level_reg == '0);
            level_out_reg  <= level_reg;
            status_out_reg <= status_reg;
        end
    end

    // result transfer
    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign popped_value = popped_out_reg;
    assign top_value    = top_out_reg;
    assign is_empty     = empty_out_reg;
    assign fill_level   = LEVEL_W'(level_out_reg);
    assign status       = status_out_reg;

endmodule

// ===== rtl/lfs_gen.sv =====
// lcg step and bit-serial remainder unit for the group push
// depends on lfs_pkg
module lfs_gen (
    input  logic                             clk,
    input  logic                             rst_n,
    input  lfs_pkg::gen_ctrl_t               ctrl,
    input  logic [lfs_pkg::DATA_W-1:0]       load_seed,
    input  logic [lfs_pkg::SPAN_W-1:0]       span,
    output lfs_pkg::gen_stat_t               stat
);
    import lfs_pkg::*;

    typedef enum logic [2:0] {
        G_IDLE = 3'b001,
        G_LOAD = 3'b010,
        G_DIV  = 3'b100
    } gen_state_t;

    gen_state_t           state_reg;
    logic [DATA_W-1:0]    seed_reg;
    logic [SEED_BITS-1:0] div_reg;
    logic [SEED_BITS-1:0] rem_reg;
    logic [4:0]           cnt_reg;
    logic                 done_reg;

    logic [DATA_W-1:0]    lcg_next;
    logic [DATA_W-1:0]    shifted;
    logic [SPAN_W-1:0]    diff;
    logic                 fits;

    // one lcg step, wrapping at 32 bits, low 31 bits kept
    assign lcg_next = (seed_reg * LCG_MUL + LCG_ADD) & {1'b0, {SEED_BITS{1'b1}}};

    // restoring remainder step
    assign shifted = {rem_reg, div_reg[SEED_BITS-1]};
    assign diff    = {1'b0, shifted} - span;
    assign fits    = ({1'b0, shifted} >= span);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= G_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            // done pulses after the last remainder step
            done_reg <= (state_reg == G_DIV) && (cnt_reg == 5'(SEED_BITS - 1));
            unique case (state_reg)
                G_IDLE:
                begin
                    if (ctrl.step)
                    begin
                        state_reg <= G_LOAD;
                    end
                end
                G_LOAD:
                begin
                    state_reg <= G_DIV;
                end
                G_DIV:
                begin
                    if (cnt_reg == 5'(SEED_BITS - 1))
                    begin
                        state_reg <= G_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= G_IDLE;
                end
            endcase
        end
    end

    // seed and divider datapath
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            seed_reg <= load_seed;
        end
        else if (state_reg == G_IDLE && ctrl.step)
        begin
            seed_reg <= lcg_next;
        end

        if (state_reg == G_LOAD)
        begin
            div_reg <= seed_reg[SEED_BITS-1:0];
            rem_reg <= '0;
            cnt_reg <= '0;
        end
        else if (state_reg == G_DIV)
        begin
            div_reg <= {div_reg[SEED_BITS-2:0], 1'b0};
            rem_reg <= fits ? diff[SEED_BITS-1:0] : shifted[SEED_BITS-1:0];
            cnt_reg <= cnt_reg + 5'd1;
        end
    end

    assign stat.done = done_reg;
    assign stat.rem  = rem_reg;

endmodule

// ===== rtl/lfs_mem.sv =====
// entry store of the stack: one write port, one registered read port
// depends on lfs_pkg
module lfs_mem #(
    parameter int DEPTH = lfs_pkg::DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [AW-1:0]              waddr,
    input  logic [lfs_pkg::DATA_W-1:0] wdata,
    input  logic                       re,
    input  logic [AW-1:0]              raddr,
    output logic [lfs_pkg::DATA_W-1:0] rdata
);
    import lfs_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sim/lifo_stack_with_lcg_fill_unit_tb.sv =====
// testbench for lifo_stack_with_lcg_fill_unit: directed table, then phased random commands
// each transfer is checked against a typed expectation or an in-bench stack and lcg fill predictor
// depends on lfs_pkg and the rtl of lifo_stack_with_lcg_fill_unit
module lifo_stack_with_lcg_fill_unit_tb;

    import lfs_pkg::*;

    localparam int STACK_DEPTH = DEPTH_DEF;
    localparam int TAIL_CYCLES = 20;

    // one command as driven on the input ports
    typedef struct packed {
        logic [1:0]         mode;
        logic [DATA_W-1:0]  push_value;
        logic [DATA_W-1:0]  range_low;
        logic [DATA_W-1:0]  range_high;
        logic [DATA_W-1:0]  start_seed;
        logic [COUNT_W-1:0] fill_count;
    } stack_cmd_t;

    // stack view reported after one command
    typedef struct packed {
        logic [DATA_W-1:0]  popped;
        logic [DATA_W-1:0]  top;
        logic               empty;
        logic [LEVEL_W-1:0] level;
        logic [1:0]         status;
    } stack_view_t;

    typedef struct packed {
        stack_cmd_t  cmd;
        logic        fixed;
        stack_view_t want;
    } directed_row_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      start = 1'b0;
    logic [1:0]                mode = MODE_PUSH;
    logic signed [DATA_W-1:0]  push_value = '0;
    logic signed [DATA_W-1:0]  range_low = '0;
    logic signed [DATA_W-1:0]  range_high = '0;
    logic signed [DATA_W-1:0]  start_seed = '0;
    logic [COUNT_W-1:0]        fill_count = '0;
    logic                      busy;
    logic                      done;
    logic signed [DATA_W-1:0]  popped_value;
    logic signed [DATA_W-1:0]  top_value;
    logic                      is_empty;
    logic [LEVEL_W-1:0]        fill_level;
    logic [1:0]                status;

    // predictor state: its own copy of the stack
    logic [DATA_W-1:0] model_entries [STACK_DEPTH];
    int unsigned       model_level;

    stack_view_t       expected_views [$];
    stack_view_t       seen_want;
    directed_row_t     directed_rows [$];
    int                mismatch_count;
    int                views_checked;

    lifo_stack_with_lcg_fill_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .mode         (mode),
        .push_value   (push_value),
        .range_low    (range_low),
        .range_high   (range_high),
        .start_seed   (start_seed),
        .fill_count   (fill_count),
        .done         (done),
        .popped_value (popped_value),
        .top_value    (top_value),
        .is_empty     (is_empty),
        .fill_level   (fill_level),
        .status       (status)
    );

    // clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // push onto the predictor stack, false when it is full
    function automatic bit model_push(input logic [DATA_W-1:0] value);
        if (model_level >= STACK_DEPTH)
            return 1'b0;
        model_entries[model_level] = value;
        model_level++;
        return 1'b1;
    endfunction

    // apply one command to the predictor stack and return the view it reports
    function automatic stack_view_t predict_stack_op(input stack_cmd_t cmd);
        stack_view_t       view;
        longint            lo;
        longint            hi;
        longint            span;
        longint            seed_wide;
        longint            value;
        logic [DATA_W-1:0] seed;
        int                i;
        view = '0;
        view.status = STATUS_OK;
        case (cmd.mode)
            MODE_PUSH:
            begin
                if (!model_push(cmd.push_value))
                    view.status = STATUS_OVERFLOW;
            end
            MODE_GROUP:
            begin
                lo = signed'(cmd.range_low);
                hi = signed'(cmd.range_high);
                if (lo > hi)
                    view.status = STATUS_RANGE;
                else
                begin
                    span = hi - lo + 1;
                    seed = cmd.start_seed;
                    for (i = 0; i < cmd.fill_count; i++)
                    begin
                        // 31-bit lcg step, product wraps at 32 bits
                        seed = (seed * LCG_MUL + LCG_ADD) & 32'h7fff_ffff;
                        seed_wide = {32'd0, seed};
                        value = lo + seed_wide % span;
                        if (!model_push(value[DATA_W-1:0]))
                        begin
                            view.status = STATUS_OVERFLOW;
                            break;
                        end
                    end
                end
            end
            MODE_POP:
            begin
                if (model_level == 0)
                    view.status = STATUS_EMPTY;
                else
                begin
                    model_level--;
                    view.popped = model_entries[model_level];
                end
            end
            default:
                model_level = 0;
        endcase
        view.top   = (model_level == 0) ? 32'hffff_ffff : model_entries[model_level-1];
        view.empty = (model_level == 0);
        view.level = model_level[LEVEL_W-1:0];
        return view;
    endfunction

    function automatic stack_cmd_t make_cmd(input logic [1:0] m, input logic [31:0] value,
                                            input logic [31:0] lo, input logic [31:0] hi,
                                            input logic [31:0] seed, input int count);
        stack_cmd_t cmd;
        cmd.mode       = m;
        cmd.push_value = value;
        cmd.range_low  = lo;
        cmd.range_high = hi;
        cmd.start_seed = seed;
        cmd.fill_count = count[COUNT_W-1:0];
        return cmd;
    endfunction

    function automatic stack_view_t make_view(input logic [31:0] popped, input logic [31:0] top,
                                              input int empty, input int level,
                                              input logic [1:0] st);
        stack_view_t view;
        view.popped = popped;
        view.top    = top;
        view.empty  = empty[0];
        view.level  = level[LEVEL_W-1:0];
        view.status = st;
        return view;
    endfunction

    // random word, weighted toward the extremes
    function automatic logic signed [31:0] rand_word();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            3: return 32'h0000_0000;
            4: return $signed($urandom_range(0, 40)) - 20;
            default: return $urandom;
        endcase
    endfunction

    // random command; weights are percentages for push, group push and pop
    function automatic stack_cmd_t random_cmd(input int push_w, input int group_w,
                                              input int pop_w);
        stack_cmd_t         cmd;
        logic signed [31:0] a;
        logic signed [31:0] b;
        longint             upper;
        int                 pick;
        cmd.push_value = rand_word();
        cmd.start_seed = $urandom;
        a = rand_word();
        b = rand_word();
        pick = $urandom_range(0, 99);
        if (pick < push_w)
            cmd.mode = MODE_PUSH;
        else if (pick < push_w + group_w)
            cmd.mode = MODE_GROUP;
        else if (pick < push_w + group_w + pop_w)
            cmd.mode = MODE_POP;
        else
            cmd.mode = MODE_CLEAR;

        // group size: mostly short, a few large, rarely beyond the depth
        pick = $urandom_range(0, 63);
        if (pick == 0)
            cmd.fill_count = COUNT_W'($urandom_range(257, 511));
        else if (pick < 4)
            cmd.fill_count = COUNT_W'($urandom_range(64, 256));
        else
            cmd.fill_count = COUNT_W'($urandom_range(0, 12));

        // range shape: inverted, full, single value, random or narrow
        case ($urandom_range(0, 9))
            0:
            begin
                if (a == b)
                begin
                    cmd.range_low  = 32'd1;
                    cmd.range_high = 32'd0;
                end
                else
                begin
                    cmd.range_low  = (a > b) ? a : b;
                    cmd.range_high = (a > b) ? b : a;
                end
            end
            1:
            begin
                cmd.range_low  = 32'h8000_0000;
                cmd.range_high = 32'h7fff_ffff;
            end
            2:
            begin
                cmd.range_low  = a;
                cmd.range_high = a;
            end
            3, 4:
            begin
                cmd.range_low  = (a > b) ? b : a;
                cmd.range_high = (a > b) ? a : b;
            end
            default:
            begin
                upper = longint'(a) + $urandom_range(0, 100);
                if (upper > 64'sd2147483647)
                    upper = 64'sd2147483647;
                cmd.range_low  = a;
                cmd.range_high = upper[31:0];
            end
        endcase
        return cmd;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch on result %0d: %s", $realtime, views_checked, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h want %h", name, got, want));
    endtask

    // drive one command and wait for its transfer; a zero gap keeps start high
    task automatic issue_command(input stack_cmd_t cmd, input int gap, input logic fixed,
                                 input stack_view_t want);
        stack_view_t predicted;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start      <= 1'b1;
        mode       <= cmd.mode;
        push_value <= cmd.push_value;
        range_low  <= cmd.range_low;
        range_high <= cmd.range_high;
        start_seed <= cmd.start_seed;
        fill_count <= cmd.fill_count;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predicted = predict_stack_op(cmd);
        expected_views.push_back(fixed ? want : predicted);
    endtask

    // hold off the sender until every outstanding result has come back
    task automatic drain_results();
        start <= 1'b0;
        while (expected_views.size() != 0)
            @(posedge clk);
    endtask

    // result checker: done marks a one-cycle transfer
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_views.size() == 0)
                report_mismatch("result with nothing expected");
            else
            begin
                seen_want = expected_views.pop_front();
                check_field("popped_value", popped_value, seen_want.popped);
                check_field("top_value", top_value, seen_want.top);
                check_field("is_empty", 32'(is_empty), 32'(seen_want.empty));
                check_field("fill_level", 32'(fill_level), 32'(seen_want.level));
                check_field("status", 32'(status), 32'(seen_want.status));
            end
            views_checked++;
        end
    end

    // directed table: typed expectation only where it is obvious
    task automatic build_directed_rows();
        directed_rows.push_back('{make_cmd(MODE_POP, 0, 0, 0, 0, 0), 1'b1,
            make_view(0, 32'hffff_ffff, 1, 0, STATUS_EMPTY)});
        directed_rows.push_back('{make_cmd(MODE_CLEAR, 0, 0, 0, 0, 0), 1'b1,
            make_view(0, 32'hffff_ffff, 1, 0, STATUS_OK)});
        directed_rows.push_back('{make_cmd(MODE_PUSH, 32'h7fff_ffff, 0, 0, 0, 0), 1'b1,
            make_view(0, 32'h7fff_ffff, 0, 1, STATUS_OK)});
        directed_rows.push_back('{make_cmd(MODE_PUSH, 32'h8000_0000, 0, 0, 0, 0), 1'b1,
            make_view(0, 32'h8000_0000, 0, 2, STATUS_OK)});
        // an entry of -1 on top looks like an empty stack apart from is_empty and fill_level
        directed_rows.push_back('{make_cmd(MODE_PUSH, 32'hffff_ffff, 0, 0, 0, 0), 1'b1,
            make_view(0, 32'hffff_ffff, 0, 3, STATUS_OK)});
        directed_rows.push_back('{make_cmd(MODE_POP, 0, 0, 0, 0, 0), 1'b1,
            make_view(32'hffff_ffff, 32'h8000_0000, 0, 2, STATUS_OK)});
        directed_rows.push_back('{make_cmd(MODE_POP, 0, 0, 0, 0, 0), 1'b1,
            make_view(32'h8000_0000, 32'h7fff_ffff, 0, 1, STATUS_OK)});
        // inverted range wins even with a zero count
        directed_rows.push_back('{make_cmd(MODE_GROUP, 0, 1, 0, 7, 0), 1'b1,
            make_view(0, 32'h7fff_ffff, 0, 1, STATUS_RANGE)});
        directed_rows.push_back('{make_cmd(MODE_GROUP, 0, 32'h7fff_ffff, 32'h8000_0000, 7, 5),
            1'b1, make_view(0, 32'h7fff_ffff, 0, 1, STATUS_RANGE)});
        directed_rows.push_back('{make_cmd(MODE_GROUP, 0, 3, 3, 9, 0), 1'b1,
            make_view(0, 32'h7fff_ffff, 0, 1, STATUS_OK)});
        // single-value ranges give known values
        directed_rows.push_back('{make_cmd(MODE_GROUP, 0, -5, -5, 1, 4), 1'b1,
            make_view(0, 32'hffff_fffb, 0, 5, STATUS_OK)});
        directed_rows.push_back('{make_cmd(MODE_GROUP, 0, 32'h8000_0000, 32'h8000_0000,
            32'hffff_ffff, 2), 1'b1, make_view(0, 32'h8000_0000, 0, 7, STATUS_OK)});
        directed_rows.push_back('{make_cmd(MODE_GROUP, 0, 32'h7fff_ffff, 32'h7fff_ffff,
            32'h8000_0000, 1), 1'b1, make_view(0, 32'h7fff_ffff, 0, 8, STATUS_OK)});
        directed_rows.push_back('{make_cmd(MODE_GROUP, 0, 32'h8000_0000, 32'h7fff_ffff,
            0, 3), 1'b0, '0});
        directed_rows.push_back('{make_cmd(MODE_GROUP, 0, 0, 32'h7fff_fffe,
            32'hffff_ffff, 2), 1'b0, '0});
        directed_rows.push_back('{make_cmd(MODE_GROUP, 0, -10, 10, 32'h8000_0000, 7),
            1'b0, '0});
        directed_rows.push_back('{make_cmd(MODE_CLEAR, 0, 0, 0, 0, 0), 1'b1,
            make_view(0, 32'hffff_ffff, 1, 0, STATUS_OK)});
        // fill exactly to the depth, overflow by push and by group push, then pop one and overfill again
        directed_rows.push_back('{make_cmd(MODE_GROUP, 0, 32'h8000_0000, 32'h7fff_ffff,
            12345, 256), 1'b0, '0});
        directed_rows.push_back('{make_cmd(MODE_PUSH, 32'h1234, 0, 0, 0, 0), 1'b0, '0});
        directed_rows.push_back('{make_cmd(MODE_GROUP, 0, 0, 9, 5, 1), 1'b0, '0});
        directed_rows.push_back('{make_cmd(MODE_POP, 0, 0, 0, 0, 0), 1'b0, '0});
        directed_rows.push_back('{make_cmd(MODE_GROUP, 0, -3, 3, 77, 511), 1'b0, '0});
        directed_rows.push_back('{make_cmd(MODE_CLEAR, 0, 0, 0, 0, 0), 1'b1,
            make_view(0, 32'hffff_ffff, 1, 0, STATUS_OK)});
        // group push past the depth from empty
        directed_rows.push_back('{make_cmd(MODE_GROUP, 0, 32'h8000_0000, 32'h7fff_ffff,
            32'h7fff_ffff, 300), 1'b0, '0});
        directed_rows.push_back('{make_cmd(MODE_CLEAR, 0, 0, 0, 0, 0), 1'b1,
            make_view(0, 32'hffff_ffff, 1, 0, STATUS_OK)});
    endtask

    // run stops here if the block hangs
    initial
    begin
        #600_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // stimulus
    initial
    begin
        int phase;
        int n;
        int kind;
        int gap;
        bit no_idle;
        mismatch_count = 0;
        views_checked  = 0;
        model_level    = 0;
        build_directed_rows();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part
        foreach (directed_rows[i])
            issue_command(directed_rows[i].cmd, $urandom_range(0, 10),
                          directed_rows[i].fixed, directed_rows[i].want);
        drain_results();

        // random part: fill-heavy, drain-heavy and balanced phases
        for (phase = 0; phase < 7; phase++)
        begin
            kind    = phase % 3;
            no_idle = (phase % 3 == 1);
            for (n = 0; n < 150; n++)
            begin
                gap = no_idle ? 0 : $urandom_range(0, 10);
                case (kind)
                    0: issue_command(random_cmd(50, 30, 19), gap, 1'b0, '0);
                    1: issue_command(random_cmd(20, 10, 66), gap, 1'b0, '0);
                    default: issue_command(random_cmd(35, 20, 40), gap, 1'b0, '0);
                endcase
            end
            drain_results();
        end

        // wait for the tail, then let the block run on idle before the verdict
        start <= 1'b0;
        while (expected_views.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
